// File: rtl/core/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared codes, field widths and lane control types of the reservation
// timeline.
// ----------------------------------------------------------------------------
package rrt_pkg;

   localparam int CMD_W      = 2;
   localparam int STS_W      = 2;
   localparam int DUR_W      = 31;
   localparam int NEED_W     = 16;
   localparam int CAP_W      = 16;
   localparam int LIMIT_W    = 16;
   localparam int DELTA_W    = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_LANES  = 3;

   localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SCHED   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNSCHED = 2'd3;

   localparam logic [STS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STS_W-1:0] ST_NOFIT = 2'd1;
   localparam logic [STS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STS_W-1:0] ST_RANGE = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] REG_GPU_CAP = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_CPU_CAP = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_RAM_CAP = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_LIMIT   = 2'd3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;

   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_INS  = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
      logic exists;
   } lane_ctl_type;

   typedef struct packed {
      logic idle;
      logic fail;
      logic have_next;
      logic has_t;
      logic has_end;
   } lane_sts_type;

endpackage

// File: rtl/core/rrt_lane.sv
// ----------------------------------------------------------------------------
// rrt_lane
// One event table (time, signed delta) kept sorted in a memory. A scan pass
// walks the table once for the fit test, the next event time and the merge
// probes; an insert pass walks down from the top, shifting entries up.
// ----------------------------------------------------------------------------
module rrt_lane #(
   parameter int MAX_EVENTS = 256,
   parameter int TIME_WIDTH = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rrt_pkg::lane_ctl_type             ctl,
   input  logic [TIME_WIDTH-1:0]             t_val,
   input  logic [TIME_WIDTH-1:0]             t_end,
   input  logic [rrt_pkg::DELTA_W-1:0]       delta,
   input  logic [rrt_pkg::NEED_W-1:0]        need,
   input  logic [rrt_pkg::CAP_W-1:0]         cap,
   output rrt_pkg::lane_sts_type             sts,
   output logic [TIME_WIDTH-1:0]             next_time,
   output logic [$clog2(MAX_EVENTS+1)-1:0]   count
);
   import rrt_pkg::*;

   localparam int AW    = $clog2(MAX_EVENTS);
   localparam int CNT_W = $clog2(MAX_EVENTS+1);
   localparam int ENT_W = TIME_WIDTH + DELTA_W;
   localparam int CUR_W = DELTA_W + AW + 2;

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_SCAN = 2'd1;
   localparam logic [1:0] L_INS  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [AW-1:0]         rd_addr_ff, rd_addr_in;
   logic [ENT_W-1:0]      rdata_ff;
   logic [CUR_W-1:0]      cur_ff, cur_in;
   logic [TIME_WIDTH-1:0] prev_ff, prev_in;
   logic                  bseen_ff, bseen_in;
   logic                  fail_ff, fail_in;
   logic                  hnext_ff, hnext_in;
   logic [TIME_WIDTH-1:0] next_ff, next_in;
   logic                  hast_ff, hast_in;
   logic                  hasend_ff, hasend_in;
   logic                  stop_ff, stop_in;
   logic                  exists_ff, exists_in;

   logic [ENT_W-1:0]      mem [MAX_EVENTS];
   logic                  we;
   logic [AW-1:0]         wa;
   logic [ENT_W-1:0]      wd;
   logic [AW-1:0]         ra;
   logic                  issue;

   logic [TIME_WIDTH-1:0] tm;
   logic [DELTA_W-1:0]    dl;
   logic [CUR_W-1:0]      dl_ext;
   logic [CUR_W-1:0]      sum_need;
   logic [CUR_W-1:0]      cap_ext;
   logic                  over;
   logic [CNT_W-1:0]      idx_dn;

   assign tm       = rdata_ff[ENT_W-1:DELTA_W];
   assign dl       = rdata_ff[DELTA_W-1:0];
   assign dl_ext   = {{(CUR_W-DELTA_W){dl[DELTA_W-1]}}, dl};
   assign sum_need = cur_ff + {{(CUR_W-NEED_W){1'b0}}, need};
   assign cap_ext  = {{(CUR_W-CAP_W){1'b0}}, cap};
   assign over     = $signed(sum_need) > $signed(cap_ext);
   assign idx_dn   = idx_ff - {{(CNT_W-1){1'b0}}, 1'b1};

   always_comb begin
      if (state_ff == L_INS) begin
         issue = (idx_ff != '0) && !stop_ff;
         ra    = idx_dn[AW-1:0];
      end else begin
         issue = (state_ff == L_SCAN) && (idx_ff < cnt_ff);
         ra    = idx_ff[AW-1:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      rd_vld_in  = 1'b0;
      rd_addr_in = ra;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      bseen_in   = bseen_ff;
      fail_in    = fail_ff;
      hnext_in   = hnext_ff;
      next_in    = next_ff;
      hast_in    = hast_ff;
      hasend_in  = hasend_ff;
      stop_in    = stop_ff;
      exists_in  = exists_ff;
      we         = 1'b0;
      wa         = rd_addr_ff + {{(AW-1){1'b0}}, 1'b1};
      wd         = rdata_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (ctl.start) begin
               if (ctl.op == OP_SCAN) begin
                  state_in  = L_SCAN;
                  idx_in    = '0;
                  cur_in    = '0;
                  prev_in   = t_val;
                  bseen_in  = 1'b0;
                  fail_in   = 1'b0;
                  hnext_in  = 1'b0;
                  hast_in   = 1'b0;
                  hasend_in = 1'b0;
               end else begin
                  state_in  = L_INS;
                  idx_in    = cnt_ff;
                  stop_in   = 1'b0;
                  exists_in = ctl.exists;
               end
            end
         end
         L_SCAN: begin
            rd_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + {{(CNT_W-1){1'b0}}, 1'b1};
            end
            if (rd_vld_ff) begin
               if (tm == t_val) hast_in = 1'b1;
               if (tm == t_end) hasend_in = 1'b1;
               if (tm <= t_val) begin
                  cur_in = cur_ff + dl_ext;
               end else begin
                  if (!hnext_ff) begin
                     hnext_in = 1'b1;
                     next_in  = tm;
                  end
                  // inside the window: test the level that held up to here
                  if (tm < t_end) begin
                     if (tm > prev_ff && over) fail_in = 1'b1;
                     cur_in   = cur_ff + dl_ext;
                     prev_in  = tm;
                     bseen_in = 1'b1;
                  end
               end
            end
            if (!issue && !rd_vld_ff) begin
               if (over && (!bseen_ff || t_end > prev_ff)) fail_in = 1'b1;
               state_in = L_IDLE;
            end
         end
         L_INS: begin
            rd_vld_in = issue;
            if (issue) idx_in = idx_dn;
            if (rd_vld_ff && !stop_ff) begin
               if (exists_ff) begin
                  if (tm == t_val) begin
                     we      = 1'b1;
                     wa      = rd_addr_ff;
                     wd      = {tm, dl + delta};
                     stop_in = 1'b1;
                  end
               end else if (tm > t_val) begin
                  we = 1'b1;
               end else begin
                  we      = 1'b1;
                  wd      = {t_val, delta};
                  stop_in = 1'b1;
               end
            end
            if (!issue && !rd_vld_ff) begin
               if (!exists_ff) begin
                  cnt_in = cnt_ff + {{(CNT_W-1){1'b0}}, 1'b1};
                  if (!stop_ff) begin
                     we = 1'b1;
                     wa = '0;
                     wd = {t_val, delta};
                  end
               end
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rdata_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= L_IDLE;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
         stop_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_vld_in;
         stop_ff   <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rd_addr_ff <= rd_addr_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      bseen_ff   <= bseen_in;
      fail_ff    <= fail_in;
      hnext_ff   <= hnext_in;
      next_ff    <= next_in;
      hast_ff    <= hast_in;
      hasend_ff  <= hasend_in;
      exists_ff  <= exists_in;
   end

   assign sts.idle      = (state_ff == L_IDLE);
   assign sts.fail      = fail_ff;
   assign sts.have_next = hnext_ff;
   assign sts.has_t     = hast_ff;
   assign sts.has_end   = hasend_ff;
   assign next_time     = next_ff;
   assign count         = cnt_ff;

endmodule

// File: rtl/core/resource_reservation_timeline.sv
// ----------------------------------------------------------------------------
// resource_reservation_timeline
// GPU/CPU/RAM reservation timeline: fit check, earliest-start search,
// schedule and unschedule over three sorted event tables.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one command per transaction; req_tready is high only
//   while the sequencer is idle, so one command is in work at a time.
//   rsp_ channel returns exactly one status/found_time per command through
//   an output register; a new command is taken while that result waits.
//   csr_ port writes capacities and the search limit; write only when idle.
// Passes (three lanes run in lockstep):
//   check        one scan of each table
//   schedule     scan, then two insert passes
//   search       one scan per candidate, up to search_limit candidates
//   range error  no scan
// Each lane's memory delivers one entry per cycle; that read port sets the
// scan and shift rate. Reset empties all tables at once through their fill
// counts (no clearing pass) and restores search_limit to 1024. A stalled
// rsp_tready holds the finished result and blocks the next completion.
// ----------------------------------------------------------------------------
module resource_reservation_timeline #(
   parameter int MAX_EVENTS = 256,
   parameter int TIME_WIDTH = 40,
   localparam int REQ_W = ((rrt_pkg::CMD_W + TIME_WIDTH + rrt_pkg::DUR_W
                           + 3*rrt_pkg::NEED_W + 7) / 8) * 8,
   localparam int RSP_W = ((rrt_pkg::STS_W + TIME_WIDTH + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cmd, start_time, duration, gpu_need, cpu_need, ram_need, zero pad
   input  logic [REQ_W-1:0]                 req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, found_time, zero pad
   output logic [RSP_W-1:0]                 rsp_tdata,
   input  logic                             csr_we,
   input  logic [rrt_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [rrt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rrt_pkg::*;

   localparam int CNT_W    = $clog2(MAX_EVENTS+1);
   localparam int RSP_BITS = STS_W + TIME_WIDTH;
   localparam int SUM_W    = ((TIME_WIDTH + 1 > DUR_W) ? TIME_WIDTH + 1 : DUR_W) + 1;
   localparam int O_ST     = CMD_W;
   localparam int O_DUR    = O_ST + TIME_WIDTH;
   localparam int O_GPU    = O_DUR + DUR_W;
   localparam int O_CPU    = O_GPU + NEED_W;
   localparam int O_RAM    = O_CPU + NEED_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_INS1 = 3'd3;
   localparam logic [2:0] S_INS2 = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [TIME_WIDTH-1:0] st_ff, st_in;
   logic [DUR_W-1:0]      dur_ff, dur_in;
   logic [NEED_W-1:0]     need_ff [NUM_LANES];
   logic [NEED_W-1:0]     need_in [NUM_LANES];
   logic [TIME_WIDTH:0]   t_ff, t_in;
   logic [TIME_WIDTH-1:0] tend_ff, tend_in;
   logic [LIMIT_W-1:0]    iter_ff, iter_in;
   logic [STS_W-1:0]      status_ff, status_in;
   logic [TIME_WIDTH-1:0] found_ff, found_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [STS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [TIME_WIDTH-1:0] rsp_found_ff, rsp_found_in;
   logic [CAP_W-1:0]      cap_ff [NUM_LANES];
   logic [CAP_W-1:0]      cap_in [NUM_LANES];
   logic [LIMIT_W-1:0]    limit_ff, limit_in;

   lane_ctl_type          ctl [NUM_LANES];
   lane_sts_type          sts [NUM_LANES];
   logic [TIME_WIDTH-1:0] nxt [NUM_LANES];
   logic [CNT_W-1:0]      cnt [NUM_LANES];
   logic [DELTA_W-1:0]    delta [NUM_LANES];
   logic [TIME_WIDTH-1:0] lane_t;

   logic                  req_accept;
   logic [SUM_W-1:0]      sum;
   logic                  range_bad;
   logic                  all_idle;
   logic                  any_fail;
   logic                  any_full;
   logic                  have_any;
   logic [TIME_WIDTH-1:0] min_next;
   logic                  start_scan;
   logic                  start_ins1;
   logic                  start_ins2;
   logic                  pos_first;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign sum        = {{(SUM_W-TIME_WIDTH-1){1'b0}}, t_ff}
                     + {{(SUM_W-DUR_W){1'b0}}, dur_ff};
   assign range_bad  = |sum[SUM_W-1:TIME_WIDTH];
   assign lane_t     = (state_ff == S_INS2) ? tend_ff : t_ff[TIME_WIDTH-1:0];
   // schedule adds at the start and removes at the end; unschedule flips it
   assign pos_first  = (cmd_ff == CMD_SCHED);

   always_comb begin
      all_idle = 1'b1;
      any_fail = 1'b0;
      any_full = 1'b0;
      have_any = 1'b0;
      min_next = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         if (!sts[i].idle) all_idle = 1'b0;
         if (sts[i].fail) any_fail = 1'b1;
         if (({1'b0, cnt[i]}
              + {{CNT_W{1'b0}}, !sts[i].has_t}
              + {{CNT_W{1'b0}}, (tend_ff != st_ff) && !sts[i].has_end})
             > (CNT_W+1)'(MAX_EVENTS)) any_full = 1'b1;
         if (sts[i].have_next && (!have_any || nxt[i] < min_next)) begin
            min_next = nxt[i];
            have_any = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      st_in         = st_ff;
      dur_in        = dur_ff;
      need_in       = need_ff;
      t_in          = t_ff;
      tend_in       = tend_ff;
      iter_in       = iter_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      cap_in        = cap_ff;
      limit_in      = limit_ff;
      start_scan    = 1'b0;
      start_ins1    = 1'b0;
      start_ins2    = 1'b0;

      if (csr_we) begin
         unique case (csr_addr)
            REG_GPU_CAP: cap_in[0] = csr_wdata;
            REG_CPU_CAP: cap_in[1] = csr_wdata;
            REG_RAM_CAP: cap_in[2] = csr_wdata;
            REG_LIMIT:   limit_in  = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in     = req_tdata[CMD_W-1:0];
               st_in      = req_tdata[O_DUR-1:O_ST];
               dur_in     = req_tdata[O_GPU-1:O_DUR];
               need_in[0] = req_tdata[O_CPU-1:O_GPU];
               need_in[1] = req_tdata[O_RAM-1:O_CPU];
               need_in[2] = req_tdata[O_RAM+NEED_W-1:O_RAM];
               t_in       = {1'b0, req_tdata[O_DUR-1:O_ST]};
               found_in   = req_tdata[O_DUR-1:O_ST];
               iter_in    = '0;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            tend_in = sum[TIME_WIDTH-1:0];
            if (cmd_ff == CMD_SEARCH && iter_ff >= limit_ff) begin
               status_in = ST_NOFIT;
               state_in  = S_OUT;
            end else if (range_bad) begin
               status_in = ST_RANGE;
               state_in  = S_OUT;
            end else begin
               start_scan = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (all_idle) begin
               case (cmd_ff)
                  CMD_CHECK: begin
                     status_in = any_fail ? ST_NOFIT : ST_OK;
                     state_in  = S_OUT;
                  end
                  CMD_SEARCH: begin
                     if (!any_fail) begin
                        status_in = ST_OK;
                        found_in  = t_ff[TIME_WIDTH-1:0];
                        state_in  = S_OUT;
                     end else begin
                        t_in     = have_any ? {1'b0, min_next}
                                            : t_ff + {{TIME_WIDTH{1'b0}}, 1'b1};
                        iter_in  = iter_ff + {{(LIMIT_W-1){1'b0}}, 1'b1};
                        state_in = S_EVAL;
                     end
                  end
                  default: begin
                     if (any_full) begin
                        status_in = ST_FULL;
                        state_in  = S_OUT;
                     end else begin
                        start_ins1 = 1'b1;
                        state_in   = S_INS1;
                     end
                  end
               endcase
            end
         end
         S_INS1: begin
            if (all_idle) begin
               start_ins2 = 1'b1;
               state_in   = S_INS2;
            end
         end
         S_INS2: begin
            if (all_idle) begin
               status_in = ST_OK;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      logic [DELTA_W-1:0] pos;
      assign pos = {{(DELTA_W-NEED_W){1'b0}}, need_ff[g]};
      assign delta[g] = ((state_ff == S_INS1) == pos_first) ? pos : ('0 - pos);
      assign ctl[g].start  = start_scan || start_ins1 || start_ins2;
      assign ctl[g].op     = start_scan ? OP_SCAN : OP_INS;
      assign ctl[g].exists = start_ins1 ? sts[g].has_t
                                        : (sts[g].has_end || tend_ff == st_ff);

      rrt_lane #(
         .MAX_EVENTS (MAX_EVENTS),
         .TIME_WIDTH (TIME_WIDTH)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[g]),
         .t_val     (lane_t),
         .t_end     (tend_ff),
         .delta     (delta[g]),
         .need      (need_ff[g]),
         .cap       (cap_ff[g]),
         .sts       (sts[g]),
         .next_time (nxt[g]),
         .count     (cnt[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         cap_ff[0]     <= '0;
         cap_ff[1]     <= '0;
         cap_ff[2]     <= '0;
         limit_ff      <= LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         cap_ff        <= cap_in;
         limit_ff      <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      st_ff         <= st_in;
      dur_ff        <= dur_in;
      need_ff       <= need_in;
      t_ff          <= t_in;
      tend_ff       <= tend_in;
      iter_ff       <= iter_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_W-RSP_BITS){1'b0}}, rsp_found_ff, rsp_status_ff};

`ifndef SYNTH
   a_idle_lanes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> all_idle)
      else $error("lane busy while sequencer idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("ready held after accepted transaction");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt[0] <= CNT_W'(MAX_EVENTS)) && (cnt[1] <= CNT_W'(MAX_EVENTS))
      && (cnt[2] <= CNT_W'(MAX_EVENTS)))
      else $error("event table count overflow");
`endif

endmodule

// File: sim/resource_reservation_timeline_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resource_reservation_timeline_checker
// Watches the req_, rsp_ and csr_ ports. It keeps its own GPU/CPU/RAM event
// tables and capacity settings, predicts the status and found_time of every
// accepted command, and compares each response against the oldest prediction.
// ----------------------------------------------------------------------------
module resource_reservation_timeline_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [127:0]  req_tdata,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [47:0]   rsp_tdata,
   input  logic          csr_we,
   input  logic [rrt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rrt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int            pending,
   output int            fail_count
);
   import rrt_pkg::*;

   localparam int NLANE = 3;
   localparam int DEPTH = 256;
   localparam logic [63:0] TMAX = 64'hFF_FFFF_FFFF;

   typedef struct {
      logic [STS_W-1:0] status;
      logic [39:0]      found_time;
   } outcome_type;

   logic [39:0] ev_time  [NLANE][DEPTH];
   logic [31:0] ev_delta [NLANE][DEPTH];
   int          ev_count [NLANE];
   longint      capacity [NLANE];
   longint      try_limit;
   outcome_type rsp_due [$];

   function automatic int lower_pos(int ln, logic [63:0] t);
      int i;
      i = 0;
      while (i < ev_count[ln] && ev_time[ln][i] < t) i++;
      return i;
   endfunction

   function automatic int slots_for(int ln, logic [63:0] t);
      int p;
      p = lower_pos(ln, t);
      return (p < ev_count[ln] && ev_time[ln][p] == t) ? 0 : 1;
   endfunction

   function automatic void add_delta(int ln, logic [63:0] t, logic [31:0] d);
      int p;
      p = lower_pos(ln, t);
      if (p < ev_count[ln] && ev_time[ln][p] == t) begin
         ev_delta[ln][p] = ev_delta[ln][p] + d;
         return;
      end
      if (ev_count[ln] >= DEPTH) return;
      for (int k = ev_count[ln]; k > p; k--) begin
         ev_time[ln][k]  = ev_time[ln][k-1];
         ev_delta[ln][k] = ev_delta[ln][k-1];
      end
      ev_time[ln][p]  = t[39:0];
      ev_delta[ln][p] = d;
      ev_count[ln]++;
   endfunction

   // usage is signed; negative after unscheduling a job never placed
   function automatic bit lane_fits(int ln, logic [63:0] t, logic [63:0] dur, longint need);
      logic [63:0] t_end, prev;
      longint      cur;
      int          i;
      t_end = t + dur;
      cur = 0;
      prev = t;
      i = 0;
      while (i < ev_count[ln] && ev_time[ln][i] <= t) begin
         cur += longint'($signed(ev_delta[ln][i]));
         i++;
      end
      if (cur + need > capacity[ln]) return 0;
      while (i < ev_count[ln] && ev_time[ln][i] < t_end) begin
         if (ev_time[ln][i] > prev && cur + need > capacity[ln]) return 0;
         cur += longint'($signed(ev_delta[ln][i]));
         prev = ev_time[ln][i];
         i++;
      end
      if (t_end > prev && cur + need > capacity[ln]) return 0;
      return 1;
   endfunction

   function automatic bit job_fits(logic [63:0] t, logic [63:0] dur, longint needs [NLANE]);
      for (int ln = 0; ln < NLANE; ln++)
         if (!lane_fits(ln, t, dur, needs[ln])) return 0;
      return 1;
   endfunction

   function automatic outcome_type predict_outcome(logic [127:0] d);
      outcome_type res;
      logic [CMD_W-1:0] cmd;
      logic [63:0] st, dur, t, e, nx;
      longint      needs [NLANE];
      logic [31:0] up [NLANE];
      logic [31:0] dn [NLANE];
      bit          have, full;
      int          i;
      cmd = d[1:0];
      st  = {24'd0, d[41:2]};
      dur = {33'd0, d[72:42]};
      for (int ln = 0; ln < NLANE; ln++) needs[ln] = longint'(d[73+16*ln +: 16]);
      res.status = ST_OK;
      res.found_time = st[39:0];
      if (cmd == CMD_SEARCH) begin
         t = st;
         res.status = ST_NOFIT;
         for (longint it = 0; it < try_limit; it++) begin
            if (t > TMAX - dur) begin
               res.status = ST_RANGE;
               break;
            end
            if (job_fits(t, dur, needs)) begin
               res.status = ST_OK;
               res.found_time = t[39:0];
               break;
            end
            have = 0;
            nx = 0;
            for (int ln = 0; ln < NLANE; ln++) begin
               i = 0;
               while (i < ev_count[ln] && ev_time[ln][i] <= t) i++;
               if (i < ev_count[ln] && (!have || ev_time[ln][i] < nx)) begin
                  nx = ev_time[ln][i];
                  have = 1;
               end
            end
            t = have ? nx : t + 1;
         end
      end else if (st > TMAX - dur) begin
         res.status = ST_RANGE;
      end else if (cmd == CMD_CHECK) begin
         res.status = job_fits(st, dur, needs) ? ST_OK : ST_NOFIT;
      end else begin
         e = st + dur;
         full = 0;
         for (int ln = 0; ln < NLANE; ln++)
            if (ev_count[ln] + slots_for(ln, st) + ((e != st) ? slots_for(ln, e) : 0) > DEPTH)
               full = 1;
         if (full) begin
            res.status = ST_FULL;
         end else begin
            for (int ln = 0; ln < NLANE; ln++) begin
               up[ln] = needs[ln];
               dn[ln] = 32'd0 - up[ln];
               if (cmd == CMD_UNSCHED) begin
                  add_delta(ln, st, dn[ln]);
                  add_delta(ln, e, up[ln]);
               end else begin
                  add_delta(ln, st, up[ln]);
                  add_delta(ln, e, dn[ln]);
               end
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         for (int ln = 0; ln < NLANE; ln++) begin
            ev_count[ln] = 0;
            capacity[ln] = 0;
         end
         try_limit = LIMIT_RESET;
         rsp_due.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_GPU_CAP: capacity[0] = csr_wdata;
               REG_CPU_CAP: capacity[1] = csr_wdata;
               REG_RAM_CAP: capacity[2] = csr_wdata;
               REG_LIMIT:   try_limit   = csr_wdata;
            endcase
         end
         if (req_tvalid && req_tready) rsp_due.push_back(predict_outcome(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.found_time = rsp_tdata[41:2];
            if (rsp_due.size() == 0) begin
               $error("response transaction with no command outstanding");
               fail_count++;
            end else begin
               want = rsp_due.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.found_time !== want.found_time) begin
                  $error("found_time: expected %0h, actual %0h",
                         want.found_time, got.found_time);
                  fail_count++;
               end
            end
         end
      end
      pending = rsp_due.size();
   end

endmodule

// File: sim/resource_reservation_timeline_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resource_reservation_timeline_tb
// Drives fit checks, searches, schedules and unschedules into the timeline
// under several capacity and search-limit settings and changing backpressure,
// then fills the tables to the brim. The checker judges every response.
// ----------------------------------------------------------------------------
module resource_reservation_timeline_tb;
   import rrt_pkg::*;

   localparam logic [39:0] TMAX = 40'hFF_FFFF_FFFF;
   localparam int STALL_LIMIT = 600000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [127:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [47:0]   rsp_tdata;
   logic          csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int            pending;
   int            fail_count;
   int            send_idle_pct;
   int            recv_idle_pct;
   bit            want_hold;
   bit            hold_done;
   int            hold_left;
   int            quiet_cycles;

   resource_reservation_timeline i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   resource_reservation_timeline_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver side: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (want_hold && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("resource_reservation_timeline regression: fail");
         $finish;
      end
   end

   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [39:0] st, logic [30:0] dur,
                           logic [15:0] g, logic [15:0] c, logic [15:0] r);
      bit ready_now;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, r, c, g, dur, st, cmd};
      forever begin
         ready_now = req_tready;
         @(posedge clock);
         if (ready_now) break;
         @(negedge clock);
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_caps(logic [15:0] g, logic [15:0] c, logic [15:0] r, logic [15:0] lim);
      write_reg(REG_GPU_CAP, g);
      write_reg(REG_CPU_CAP, c);
      write_reg(REG_RAM_CAP, r);
      write_reg(REG_LIMIT, lim);
   endtask

   function automatic logic [15:0] rand_need;
      return ($urandom_range(9) < 3) ? 16'($urandom) : 16'($urandom_range(400));
   endfunction

   // times mostly from a small grid so events merge and tables stay short
   task automatic send_random;
      logic [CMD_W-1:0] cmd;
      logic [39:0]      st;
      logic [30:0]      dur;
      int               pick;
      pick = $urandom_range(99);
      cmd = (pick < 30) ? CMD_CHECK : (pick < 55) ? CMD_SEARCH :
            (pick < 85) ? CMD_SCHED : CMD_UNSCHED;
      pick = $urandom_range(99);
      if (pick < 85) st = 40'(16 * $urandom_range(40));
      else if (pick < 90) st = {8'($urandom), 32'($urandom)};
      else if (pick < 95) st = TMAX - 40'($urandom_range(50));
      else st = 40'($urandom_range(1000));
      if (pick >= 85 && pick < 90 && (cmd == CMD_SCHED || cmd == CMD_UNSCHED)
          && $urandom_range(2) != 0)
         st = 40'(16 * $urandom_range(40));
      pick = $urandom_range(99);
      if (pick < 15) dur = 31'd0;
      else if (pick < 75) dur = 31'(16 * $urandom_range(1, 8));
      else if (pick < 87) dur = 31'($urandom);
      else dur = 31'($urandom_range(1, 40));
      send_cmd(cmd, st, dur, rand_need(), rand_need(), rand_need());
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      send_idle_pct = 36;
      recv_idle_pct = 45;
      want_hold = 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty tables, reset capacities and reset search limit
      send_cmd(CMD_CHECK, 40'd0, 31'd5, 16'd0, 16'd0, 16'd0);
      send_cmd(CMD_CHECK, 40'd0, 31'd5, 16'd1, 16'd0, 16'd0);
      send_cmd(CMD_SEARCH, 40'd7, 31'd3, 16'd0, 16'd1, 16'd0);
      send_cmd(CMD_CHECK, TMAX, 31'd1, 16'd0, 16'd0, 16'd0);
      drain();
      set_caps(16'd100, 16'd100, 16'd100, 16'd0);
      send_cmd(CMD_SEARCH, 40'd0, 31'd1, 16'd0, 16'd0, 16'd0);
      drain();
      write_reg(REG_LIMIT, 16'd20);
      send_cmd(CMD_SCHED, 40'd10, 31'd20, 16'd60, 16'd60, 16'd60);
      send_cmd(CMD_CHECK, 40'd20, 31'd5, 16'd50, 16'd0, 16'd0);
      send_cmd(CMD_CHECK, 40'd30, 31'd5, 16'd50, 16'd50, 16'd50);
      send_cmd(CMD_SEARCH, 40'd0, 31'd15, 16'd50, 16'd10, 16'd10);
      send_cmd(CMD_SCHED, 40'd30, 31'd0, 16'd5, 16'd5, 16'd5);
      send_cmd(CMD_SCHED, 40'd10, 31'd20, 16'd60, 16'd60, 16'd60);
      send_cmd(CMD_UNSCHED, 40'd10, 31'd20, 16'd60, 16'd60, 16'd60);
      send_cmd(CMD_UNSCHED, 40'd100, 31'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(CMD_CHECK, 40'd100, 31'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(CMD_SCHED, TMAX - 40'd3, 31'd4, 16'd1, 16'd1, 16'd1);
      send_cmd(CMD_UNSCHED, TMAX, 31'h7FFF_FFFF, 16'd1, 16'd1, 16'd1);
      send_cmd(CMD_SEARCH, TMAX - 40'd2, 31'd2, 16'hFFFF, 16'd0, 16'd0);
      send_cmd(CMD_CHECK, 40'd0, 31'h7FFF_FFFF, 16'd0, 16'd0, 16'd0);
      send_cmd(CMD_SCHED, TMAX, 31'd0, 16'd0, 16'd0, 16'd0);
      send_cmd(CMD_SEARCH, 40'd0, 31'd5, 16'd0, 16'd0, 16'hFFFF);
      drain();
      set_caps(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
      send_cmd(CMD_SEARCH, 40'd5, 31'd40, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(CMD_CHECK, 40'd5, 31'd40, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 45 : 0;
         recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 36 : 0;
         case (phase)
            0: set_caps(16'($urandom_range(300, 900)), 16'($urandom_range(300, 900)),
                        16'($urandom_range(300, 900)), 16'd4);
            1: set_caps(16'($urandom), 16'($urandom_range(200, 600)),
                        16'($urandom_range(200, 600)), 16'($urandom_range(2, 8)));
            default: set_caps(16'd0, 16'hFFFF, 16'($urandom_range(500, 2000)), 16'd8);
         endcase
         for (int n = 0; n < 410; n++) begin
            if (phase == 0 && n == 50) want_hold = 1'b1;
            send_random();
         end
         drain();
      end

      // fill every table, then ask for more room than is left
      set_caps(16'd1000, 16'd1000, 16'd1000, 16'd2);
      for (int k = 0; k < 140; k++)
         send_cmd(CMD_SCHED, 40'h80_0000_0000 + 40'(4 * k), 31'd1, 16'd1, 16'd2, 16'd3);
      send_cmd(CMD_SCHED, 40'h80_0000_0000, 31'd4, 16'd1, 16'd1, 16'd1);
      send_cmd(CMD_UNSCHED, 40'h80_0000_0003, 31'd0, 16'd1, 16'd1, 16'd1);
      send_cmd(CMD_SEARCH, 40'h80_0000_0000, 31'd2, 16'd999, 16'd0, 16'd0);
      send_cmd(CMD_CHECK, 40'h80_0000_0000, 31'd100, 16'd1, 16'd1, 16'd1);
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("resource_reservation_timeline regression: pass");
      end else begin
         $display("resource_reservation_timeline regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/rrt_pkg.sv
rtl/core/rrt_lane.sv
rtl/core/resource_reservation_timeline.sv
sim/resource_reservation_timeline_checker.sv
sim/resource_reservation_timeline_tb.sv
